>>> sv/ppd_pkg.sv
package ppd_pkg;

    // Item widths fixed by the pixel and result formats
    localparam int RES_W    = 36;   // clamped residual, twelve times input scale
    localparam int RE_W     = 38;   // |Re r13| magnitude
    localparam int IM_W     = 35;   // |Im r13| magnitude
    localparam int NUM_W    = 77;   // |r13|^2 numerator
    localparam int Q_W      = 61;   // quotient kept up to the cap
    localparam int D12_W    = 44;   // power before the divide by twelve
    localparam int P_W      = 62;   // power sum width
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW  = 2;

    localparam logic [Q_W-1:0]  Q_CAP   = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [P_W-1:0]  SAT_LIM = P_W'(12) << 40;
    localparam logic [39:0]     MAX40   = '1;
    // ceil(2^44 / 3): exact floor division by three for operands below 2^43
    localparam logic [42:0]     RECIP3  = 43'h555_5555_5556;

    typedef struct packed {
        logic [31:0]        c11_power;
        logic [31:0]        c22_power;
        logic [31:0]        c33_power;
        logic signed [31:0] c13_real;
        logic signed [31:0] c13_imag;
        logic signed [31:0] c12_imag;
        logic signed [31:0] c23_imag;
    } pixel_t;

    typedef struct packed {
        logic [39:0]        surface_power;
        logic [39:0]        double_power;
        logic signed [35:0] volume_power;
        logic [32:0]        helix_power;
        logic               saturated;
    } power_t;

    // Payload that rides alongside the division
    typedef struct packed {
        logic [RES_W-1:0]   div;
        logic [RES_W-1:0]   plus;
        logic [RES_W-1:0]   minus;
        logic               swap;
        logic signed [35:0] vol;
        logic [32:0]        helix;
    } carry_t;

    typedef struct packed {
        carry_t             c;
        logic [RE_W-1:0]    re_mag;
        logic [IM_W-1:0]    im_mag;
    } work_t;

    typedef struct packed {
        carry_t             c;
        logic [63:0]        re_ll;
        logic [RE_W-1:0]    re_hl;
        logic [11:0]        re_hh;
        logic [63:0]        im_ll;
        logic [IM_W-1:0]    im_hl;
        logic [5:0]         im_hh;
    } prod_t;

    typedef struct packed {
        carry_t             c;
        logic [NUM_W-1:0]   re2;
        logic [NUM_W-1:0]   im2;
    } sq_t;

    typedef struct packed {
        carry_t             c;
        logic [NUM_W-1:0]   num;
        logic [RES_W-1:0]   rem;
        logic [Q_W-1:0]     q;
        logic               big;
    } dstg_t;

    typedef struct packed {
        logic [D12_W-1:0]   s_num;
        logic               s_sat;
        logic [D12_W-1:0]   d_num;
        logic               d_sat;
        logic signed [35:0] vol;
        logic [32:0]        helix;
    } tstg_t;

    // Partial products of a quarter power and the reciprocal of three
    typedef struct packed {
        logic [42:0]        hh;
        logic [41:0]        hl;
        logic [42:0]        lh;
        logic [41:0]        ll;
    } recip_t;

    typedef struct packed {
        recip_t             s_prod;
        logic               s_sat;
        recip_t             d_prod;
        logic               d_sat;
        logic signed [35:0] vol;
        logic [32:0]        helix;
    } mstg_t;

endpackage

>>> sv/ppd_front.sv
module ppd_front import ppd_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   model_select,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   push,
    output work_t  work,
    input  logic   full
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pix_reg;
    logic   load;

    logic signed [33:0] s;
    logic signed [39:0] s40;
    logic signed [39:0] c11e, c22e, c33e, c13r, c13i;
    logic signed [39:0] r11, r33, rre, rim, vol;
    logic [39:0]        rre_abs, rim_abs;
    logic [33:0]        s_abs;
    logic [35:0]        s3;
    logic [RES_W-1:0]   r11c, r33c;

    assign pixel_stall = valid_reg && full;
    assign load        = pixel_valid && !pixel_stall;
    assign push        = valid_reg && !full;
    assign valid_next  = load || (valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pixel;
        end
    end

    // Residuals at twelve times input scale, exact in 40 bits
    always_comb
    begin
        s    = model_select ? ($signed({{2{pix_reg.c12_imag[31]}}, pix_reg.c12_imag})
                             + $signed({{2{pix_reg.c23_imag[31]}}, pix_reg.c23_imag}))
                            : '0;
        s40  = {{6{s[33]}}, s};
        c11e = $signed({8'd0, pix_reg.c11_power});
        c22e = $signed({8'd0, pix_reg.c22_power});
        c33e = $signed({8'd0, pix_reg.c33_power});
        c13r = $signed({{8{pix_reg.c13_real[31]}}, pix_reg.c13_real});
        c13i = $signed({{8{pix_reg.c13_imag[31]}}, pix_reg.c13_imag});
        r11  = 40'sd12 * c11e - 40'sd18 * c22e - 40'sd3 * s40;
        r33  = 40'sd12 * c33e - 40'sd18 * c22e - 40'sd3 * s40;
        rre  = 40'sd12 * c13r - 40'sd6 * c22e - 40'sd9 * s40;
        rim  = 40'sd12 * c13i;
        vol  = 40'sd4 * c22e + 40'sd2 * s40;
        rre_abs = rre[39] ? 40'(-rre) : 40'(rre);
        rim_abs = rim[39] ? 40'(-rim) : 40'(rim);
        s_abs   = s[33] ? 34'(-s) : 34'(s);
        s3      = 36'(s_abs) * 36'd3;
        r11c    = r11[39] ? '0 : r11[RES_W-1:0];
        r33c    = r33[39] ? '0 : r33[RES_W-1:0];

        // Negative Re r13 takes the double-bounce branch
        work.c.swap   = rre[39];
        work.c.div    = rre[39] ? r33c : r11c;
        work.c.plus   = rre[39] ? r33c : r11c;
        work.c.minus  = rre[39] ? r11c : r33c;
        work.c.vol    = vol[35:0];
        work.c.helix  = s3[33:1];
        work.re_mag   = rre_abs[RE_W-1:0];
        work.im_mag   = rim_abs[IM_W-1:0];
    end

endmodule

>>> sv/ppd_fifo.sv
module ppd_fifo import ppd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t wdata,
    output logic  full,
    input  logic  pop,
    output work_t rdata,
    output logic  empty
);

    work_t              mem [FIFO_DEPTH];
    work_t              rdata_reg;
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = rdata_reg;

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The popped request appears on rdata the cycle after pop
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
        if (pop)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

endmodule

>>> sv/ppd_back.sv
module ppd_back import ppd_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   empty,
    input  work_t  work,
    output logic   pop,
    output logic   power_valid,
    input  logic   power_stall,
    output power_t power
);

    logic adv;

    prod_t pr_reg, pr_next;
    sq_t   sq_reg, sq_next;
    dstg_t nm_reg, nm_next;
    logic  rd_vld_reg, pr_vld_reg, sq_vld_reg, nm_vld_reg, cm_vld_reg, ml_vld_reg;
    logic  out_vld_reg;

    dstg_t dv_reg  [NUM_W];
    dstg_t dv_next [NUM_W];
    logic [NUM_W-1:0] dv_vld_reg;

    tstg_t cm_reg, cm_next;
    mstg_t ml_reg, ml_next;

    power_t out_reg, out_next;

    logic [Q_W-1:0] q_eff;
    logic [P_W-1:0] psum, pdif, p_s, p_d;

    function automatic recip_t recip_parts(logic [D12_W-1:0] p);
        logic [41:0] y;
        recip_t      r;
        y    = p[D12_W-1:2];
        r.hh = 43'(y[41:21]) * 43'(RECIP3[42:21]);
        r.hl = 42'(y[41:21]) * 42'(RECIP3[20:0]);
        r.lh = 43'(y[20:0]) * 43'(RECIP3[42:21]);
        r.ll = 42'(y[20:0]) * 42'(RECIP3[20:0]);
        return r;
    endfunction

    function automatic logic [39:0] recip_sum(recip_t r);
        logic [85:0] acc;
        acc = (86'(r.hh) << 42) + (86'(r.hl) << 21) + (86'(r.lh) << 21) + 86'(r.ll);
        return acc[83:44];
    endfunction

    // The whole pipeline moves together; hold everything while the result is stalled
    assign adv         = !(out_vld_reg && power_stall);
    assign pop         = adv && !empty;
    assign power_valid = out_vld_reg;
    assign power       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            pr_vld_reg  <= 1'b0;
            sq_vld_reg  <= 1'b0;
            nm_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            cm_vld_reg  <= 1'b0;
            ml_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            rd_vld_reg  <= !empty;
            pr_vld_reg  <= rd_vld_reg;
            sq_vld_reg  <= pr_vld_reg;
            nm_vld_reg  <= sq_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[NUM_W-2:0], nm_vld_reg};
            cm_vld_reg  <= dv_vld_reg[NUM_W-1];
            ml_vld_reg  <= cm_vld_reg;
            out_vld_reg <= ml_vld_reg;
        end
    end

    // Partial products of the two squares, the squares, and their sum as the numerator
    always_comb
    begin
        pr_next.c     = work.c;
        pr_next.re_ll = 64'(work.re_mag[31:0]) * 64'(work.re_mag[31:0]);
        pr_next.re_hl = RE_W'(work.re_mag[RE_W-1:32]) * RE_W'(work.re_mag[31:0]);
        pr_next.re_hh = 12'(work.re_mag[RE_W-1:32]) * 12'(work.re_mag[RE_W-1:32]);
        pr_next.im_ll = 64'(work.im_mag[31:0]) * 64'(work.im_mag[31:0]);
        pr_next.im_hl = IM_W'(work.im_mag[IM_W-1:32]) * IM_W'(work.im_mag[31:0]);
        pr_next.im_hh = 6'(work.im_mag[IM_W-1:32]) * 6'(work.im_mag[IM_W-1:32]);

        sq_next.c   = pr_reg.c;
        sq_next.re2 = NUM_W'(pr_reg.re_ll) + (NUM_W'(pr_reg.re_hl) << 33)
                    + (NUM_W'(pr_reg.re_hh) << 64);
        sq_next.im2 = NUM_W'(pr_reg.im_ll) + (NUM_W'(pr_reg.im_hl) << 33)
                    + (NUM_W'(pr_reg.im_hh) << 64);

        nm_next.c   = sq_reg.c;
        nm_next.num = sq_reg.re2 + sq_reg.im2;
        nm_next.rem = '0;
        nm_next.q   = '0;
        nm_next.big = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg <= pr_next;
            sq_reg <= sq_next;
            nm_reg <= nm_next;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        dstg_t             src;
        logic [RES_W:0]    trial;
        logic              ge;

        assign src = (k == 0) ? nm_reg : dv_reg[(k == 0) ? 0 : k-1];

        always_comb
        begin
            trial      = {src.rem, src.num[NUM_W-1]};
            ge         = trial >= {1'b0, src.c.div};
            dv_next[k].c   = src.c;
            dv_next[k].num = {src.num[NUM_W-2:0], 1'b0};
            dv_next[k].rem = ge ? RES_W'(trial - {1'b0, src.c.div}) : trial[RES_W-1:0];
            dv_next[k].q   = {src.q[Q_W-2:0], ge};
            dv_next[k].big = src.big || src.q[Q_W-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // Apply the quotient to both residuals and flag oversized powers
    always_comb
    begin
        if (dv_reg[NUM_W-1].c.div == '0)
        begin
            q_eff = '0;
        end
        else if (dv_reg[NUM_W-1].big || dv_reg[NUM_W-1].q > Q_CAP)
        begin
            q_eff = Q_CAP;
        end
        else
        begin
            q_eff = dv_reg[NUM_W-1].q;
        end
        psum = P_W'(dv_reg[NUM_W-1].c.plus) + P_W'(q_eff);
        pdif = (P_W'(dv_reg[NUM_W-1].c.minus) >= P_W'(q_eff))
             ? P_W'(dv_reg[NUM_W-1].c.minus) - P_W'(q_eff) : '0;
        p_s  = dv_reg[NUM_W-1].c.swap ? pdif : psum;
        p_d  = dv_reg[NUM_W-1].c.swap ? psum : pdif;

        cm_next.s_num = p_s[D12_W-1:0];
        cm_next.s_sat = p_s >= SAT_LIM;
        cm_next.d_num = p_d[D12_W-1:0];
        cm_next.d_sat = p_d >= SAT_LIM;
        cm_next.vol   = dv_reg[NUM_W-1].c.vol;
        cm_next.helix = dv_reg[NUM_W-1].c.helix;
    end

    // Divide both powers by twelve: drop two bits, then multiply by the reciprocal of three
    always_comb
    begin
        ml_next.s_prod = recip_parts(cm_reg.s_num);
        ml_next.s_sat  = cm_reg.s_sat;
        ml_next.d_prod = recip_parts(cm_reg.d_num);
        ml_next.d_sat  = cm_reg.d_sat;
        ml_next.vol    = cm_reg.vol;
        ml_next.helix  = cm_reg.helix;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cm_reg <= cm_next;
            ml_reg <= ml_next;
        end
    end

    always_comb
    begin
        out_next.surface_power = ml_reg.s_sat ? MAX40 : recip_sum(ml_reg.s_prod);
        out_next.double_power  = ml_reg.d_sat ? MAX40 : recip_sum(ml_reg.d_prod);
        out_next.volume_power  = ml_reg.vol;
        out_next.helix_power   = ml_reg.helix;
        out_next.saturated     = ml_reg.s_sat || ml_reg.d_sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> sv/polarimetric_power_decomposition_unit.sv
// Scattering-power decomposition of one polarimetric covariance pixel.
// The pixel channel (pixel_valid, pixel_stall, pixel) takes the averaged
// covariance terms in Q16.16; the power channel (power_valid, power_stall,
// power) returns surface, double-bounce, volume and helix powers and a
// saturation flag, one result per pixel and in pixel order.
// cfg_write with cfg_data selects the model: 0 three-component, 1
// four-component with helix. Write it only while the block is empty.
// Throughput is one pixel per cycle while power_stall does not hold the
// result. With an empty queue the path from the front register runs:
// one queue write, one registered queue read, three stages for the
// squared magnitude, 77 stages of restoring division (one quotient bit
// each), one stage to combine residuals, one reciprocal-multiply stage for
// the divide by twelve, then the output register.
// A four-entry queue sits between the front and the back pipeline. While a
// valid result is held by power_stall the whole back pipeline holds and the
// result stays unchanged; the front keeps accepting until the queue fills.
// Reset clears all valid state and sets the model to three-component.
module polarimetric_power_decomposition_unit import ppd_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_write,
    input  logic   cfg_data,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   power_valid,
    input  logic   power_stall,
    output power_t power
);

    logic  model_reg;
    logic  push, full, pop, empty;
    work_t wdata, rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            model_reg <= cfg_data;
        end
    end

    ppd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .model_select (model_reg),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .push         (push),
        .work         (wdata),
        .full         (full)
    );

    ppd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .full  (full),
        .pop   (pop),
        .rdata (rdata),
        .empty (empty)
    );

    ppd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .work        (rdata),
        .pop         (pop),
        .power_valid (power_valid),
        .power_stall (power_stall),
        .power       (power)
    );

endmodule

>>> test/ppd_checker.sv
`timescale 1ns / 100ps

module ppd_checker import ppd_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_write,
    input  logic   cfg_data,
    input  logic   pixel_valid,
    input  logic   pixel_stall,
    input  pixel_t pixel,
    input  logic   power_valid,
    input  logic   power_stall,
    input  power_t power,
    output int     errors,
    output int     pending
);

    logic   helix_mode;
    power_t expected_powers[$];

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [39:0] scale_down(longint p12, ref logic clipped);
        longint v;
        v = (p12 <= 0) ? 0 : p12 / 12;
        if (v > longint'(MAX40))
        begin
            clipped = 1'b1;
            return MAX40;
        end
        return v[39:0];
    endfunction

    function automatic power_t decompose(pixel_t p, logic mode);
        longint       c11, c22, c33, s, r11, r33, rre, rim, ps, pd, vol, q;
        logic [127:0] num, quo;
        logic [63:0]  hx;
        logic         clipped;
        power_t       r;
        c11 = longint'({32'b0, p.c11_power});
        c22 = longint'({32'b0, p.c22_power});
        c33 = longint'({32'b0, p.c33_power});
        s   = mode ? longint'(p.c12_imag) + longint'(p.c23_imag) : 0;
        r11 = 12 * c11 - 18 * c22 - 3 * s;
        r33 = 12 * c33 - 18 * c22 - 3 * s;
        rre = 12 * longint'(p.c13_real) - 6 * c22 - 9 * s;
        rim = 12 * longint'(p.c13_imag);
        if (r11 < 0) r11 = 0;
        if (r33 < 0) r33 = 0;
        num = 128'(magnitude(rre)) * 128'(magnitude(rre))
            + 128'(magnitude(rim)) * 128'(magnitude(rim));
        if (rre >= 0)
        begin
            if (r11 > 0)
            begin
                quo = num / 128'(r11);
                q   = (quo > (128'd1 << 60)) ? (longint'(1) << 60) : longint'(quo[63:0]);
                pd  = r33 - q;
                if (pd < 0) pd = 0;
                ps  = r11 + q;
            end
            else
            begin
                pd = r33;
                ps = 0;
            end
        end
        else
        begin
            if (r33 > 0)
            begin
                quo = num / 128'(r33);
                q   = (quo > (128'd1 << 60)) ? (longint'(1) << 60) : longint'(quo[63:0]);
                ps  = r11 - q;
                if (ps < 0) ps = 0;
                pd  = r33 + q;
            end
            else
            begin
                ps = r11;
                pd = 0;
            end
        end
        vol = 4 * c22 + 2 * s;
        if (vol > 64'sd34359738367) vol = 64'sd34359738367;
        if (vol < -64'sd34359738368) vol = -64'sd34359738368;
        clipped         = 1'b0;
        r.surface_power = scale_down(ps, clipped);
        r.double_power  = scale_down(pd, clipped);
        r.volume_power  = vol[35:0];
        hx              = (magnitude(s) * 3) >> 1;
        r.helix_power   = mode ? hx[32:0] : 33'd0;
        r.saturated     = clipped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        power_t want;
        if (!rst_n)
        begin
            helix_mode = 1'b0;
            errors     = 0;
            expected_powers.delete();
        end
        else
        begin
            if (cfg_write)
                helix_mode = cfg_data;
            if (pixel_valid && !pixel_stall)
                expected_powers.push_back(decompose(pixel, helix_mode));
            if (power_valid && !power_stall)
            begin
                if (expected_powers.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", power);
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (want.surface_power !== power.surface_power
                        || want.double_power !== power.double_power
                        || want.volume_power !== power.volume_power
                        || want.helix_power !== power.helix_power
                        || want.saturated !== power.saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp s=%h d=%h v=%h h=%h f=%b got s=%h d=%h v=%h h=%h f=%b",
                                want.surface_power, want.double_power, want.volume_power,
                                want.helix_power, want.saturated, power.surface_power,
                                power.double_power, power.volume_power, power.helix_power,
                                power.saturated);
                    end
                end
            end
        end
        pending = expected_powers.size();
    end

endmodule

>>> test/tb_polarimetric_power_decomposition_unit.sv
`timescale 1ns / 100ps

module tb_polarimetric_power_decomposition_unit;
    import ppd_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_write = 1'b0;
    logic   cfg_data = 1'b0;
    logic   pixel_valid = 1'b0;
    logic   pixel_stall;
    pixel_t pixel = '0;
    logic   power_valid;
    logic   power_stall = 1'b0;
    power_t power;
    int     errors;
    int     pending;
    int     send_pct = 0;
    int     recv_pct = 0;
    int     hold_cnt = 0;
    logic   hold_req = 1'b0;
    logic   hold_done = 1'b0;

    polarimetric_power_decomposition_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
        .power_valid(power_valid), .power_stall(power_stall), .power(power)
    );

    ppd_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
        .power_valid(power_valid), .power_stall(power_stall), .power(power),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off so the queue fills
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt    <= hold_cnt - 1;
            power_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt    <= 400;
            hold_done   <= 1'b1;
            power_stall <= 1'b1;
        end
        else
            power_stall <= ($urandom_range(99) < recv_pct);
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_pixel(pixel_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (pixel_stall);
    endtask

    task automatic set_model(logic m);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    function automatic pixel_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d, logic [31:0] e, logic [31:0] f,
                                  logic [31:0] g);
        pixel_t p;
        p = {a, b, c, d, e, f, g};
        return p;
    endfunction

    task automatic directed_pixels;
        send_pixel(mk(0, 0, 0, 0, 0, 0, 0));
        send_pixel('1);
        send_pixel(mk('1, '1, '1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_pixel(mk('1, 0, '1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        send_pixel(mk('1, 0, '1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
        // clipped surface and double-bounce powers: tiny residual under a huge cross term
        send_pixel(mk(1, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0));
        send_pixel(mk(0, 0, 1, 32'h80000000, 32'h7fffffff, 0, 0));
        // zero residual on the chosen branch
        send_pixel(mk(0, 0, 32'h00050000, 32'h00010000, 0, 0, 0));
        send_pixel(mk(32'h00050000, 0, 0, 32'hffff0000, 0, 0, 0));
        // reduced residual driven negative
        send_pixel(mk(32'h00010000, 0, 32'h00010000, 32'h00100000, 32'h00100000, 0, 0));
        send_pixel(mk(32'h00010000, 0, 32'h00010000, 32'hfff00000, 32'hfff00000, 0, 0));
        send_pixel(mk(32'h00300000, 32'h00010000, 32'h00200000, 32'h00008000,
                      32'hffff8000, 32'h00004000, 32'hffffc000));
        send_pixel(mk(32'h00300000, 32'h00010000, 32'h00200000, 32'hffff8000,
                      32'h00008000, 32'h80000000, 32'h80000000));
    endtask

    function automatic pixel_t random_pixel;
        pixel_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0)
        begin
            // plausible pixel: diagonal powers dominate, cross terms small
            p.c11_power = $urandom_range(32'h00400000);
            p.c22_power = $urandom_range(32'h00080000);
            p.c33_power = $urandom_range(32'h00400000);
            p.c13_real  = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
            p.c13_imag  = $signed($urandom_range(32'h00100000)) - 32'sh00080000;
            p.c12_imag  = $signed($urandom_range(32'h00040000)) - 32'sh00020000;
            p.c23_imag  = $signed($urandom_range(32'h00040000)) - 32'sh00020000;
        end
        return p;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_pct = (ph == 0) ? 10 : (ph == 1) ? 77 : 0;
            recv_pct = (ph == 0) ? 77 : (ph == 1) ? 10 : 0;
            set_model(ph == 1 || ph == 2);
            if (ph < 2)
                directed_pixels();
            if (ph == 2)
                hold_req <= 1'b1;
            repeat (200) send_pixel(random_pixel());
            drain();
        end
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
